// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/whm_pkg.sv =====
// ----------------------------------------------------------------------------
// whm_pkg
// shared types and constants of the windowed timeout health monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package whm_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = 16 + PTR_W;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVITY_FLOOR = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEGRADED_RATE  = 4'd1;

    localparam logic [15:0] ACTIVITY_FLOOR_RESET = 16'd4;
    localparam logic [8:0]  DEGRADED_RATE_RESET  = 9'd128;

    localparam logic [1:0] MARK_HEALTHY  = 2'd0;
    localparam logic [1:0] MARK_DEGRADED = 2'd1;
    localparam logic [1:0] MARK_NONE     = 2'd2;

    localparam logic [1:0] HS_ONLINE   = 2'd0;
    localparam logic [1:0] HS_DEGRADED = 2'd1;
    localparam logic [1:0] HS_OFFLINE  = 2'd2;

    typedef struct packed {
        logic [15:0] tick_responses;
        logic [15:0] tick_timeouts;
    } t_in_item;

    typedef struct packed {
        logic [1:0] health_state;
        logic       evaluated;
    } t_out_item;

    typedef struct packed {
        logic [15:0] responses;
        logic [15:0] timeouts;
        logic        degraded;
    } t_work_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_queue_status;

    typedef struct packed {
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] degraded_count;
        logic [CNT_W-1:0] healthy_count;
    } t_back_status;

endpackage

// ===== design/whm_queue.sv =====
// ----------------------------------------------------------------------------
// whm_queue
// short request queue between the classifying front and the window back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module whm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  whm_pkg::t_work_item    i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output whm_pkg::t_work_item    o_item,
    output whm_pkg::t_queue_status o_status
);
    import whm_pkg::*;

    t_work_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;
    logic                push;
    logic                pop;

    assign o_ready         = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid         = (r_count != '0);
    assign o_item          = r_mem[r_rd_ptr];
    assign o_status.count  = r_count;
    assign push            = i_valid && o_ready;
    assign pop             = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/whm_front.sv =====
// ----------------------------------------------------------------------------
// whm_front
// accepts tick requests and classifies each tick against the timeout rate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module whm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  whm_pkg::t_in_item   i_item,
    input  logic [8:0]          i_degraded_rate_q8,
    output logic                o_valid,
    input  logic                i_ready,
    output whm_pkg::t_work_item o_item
);
    import whm_pkg::*;

    logic        r_valid;
    t_work_item  r_item;
    logic        n_valid;
    t_work_item  n_item;
    logic [16:0] activity;
    logic [25:0] limit;
    logic [25:0] scaled_timeouts;
    logic        accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // degraded when timeouts * 256 > rate * (responses + timeouts)
    assign activity        = {1'b0, i_item.tick_responses} + {1'b0, i_item.tick_timeouts};
    assign limit           = {17'd0, i_degraded_rate_q8} * {9'd0, activity};
    assign scaled_timeouts = {2'd0, i_item.tick_timeouts, 8'd0};

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (accept) begin
            n_valid          = 1'b1;
            n_item.responses = i_item.tick_responses;
            n_item.timeouts  = i_item.tick_timeouts;
            n_item.degraded  = (scaled_timeouts > limit);
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

// ===== design/whm_back.sv =====
// ----------------------------------------------------------------------------
// whm_back
// circular window, running sums, mark counts and health state update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module whm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  whm_pkg::t_work_item   i_item,
    input  logic [15:0]           i_activity_floor,
    output logic                  o_valid,
    input  logic                  i_ready,
    output whm_pkg::t_out_item    o_item,
    output whm_pkg::t_back_status o_status
);
    import whm_pkg::*;

    logic [15:0]      r_win_responses [WINDOW_DEPTH];
    logic [15:0]      r_win_timeouts  [WINDOW_DEPTH];
    logic [1:0]       r_win_mark      [WINDOW_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [CNT_W-1:0] r_fill;
    logic [SUM_W-1:0] r_sum_resp;
    logic [SUM_W-1:0] r_sum_tmo;
    logic [CNT_W-1:0] r_deg_cnt;
    logic [CNT_W-1:0] r_hlt_cnt;
    logic [1:0]       r_health;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] n_fill;
    logic [SUM_W-1:0] n_sum_resp;
    logic [SUM_W-1:0] n_sum_tmo;
    logic [CNT_W-1:0] n_deg_cnt;
    logic [CNT_W-1:0] n_hlt_cnt;
    logic [1:0]       n_health;
    logic [1:0]       n_mark;

    logic             pop;
    logic             was_full;
    logic [1:0]       old_mark;
    logic [SUM_W-1:0] base_resp;
    logic [SUM_W-1:0] base_tmo;
    logic [CNT_W-1:0] base_deg;
    logic [CNT_W-1:0] base_hlt;
    logic [SUM_W:0]   window_activity;
    logic             evaluate;

    assign o_ready  = !r_out_valid || i_ready;
    assign pop      = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out_item;

    assign o_status.fill_count     = r_fill;
    assign o_status.degraded_count = r_deg_cnt;
    assign o_status.healthy_count  = r_hlt_cnt;

    assign n_head   = (r_head == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign was_full = (r_fill == CNT_W'(WINDOW_DEPTH));
    assign old_mark = r_win_mark[n_head];

    // retire the overwritten entry once the window is full
    always_comb begin
        base_resp = r_sum_resp;
        base_tmo  = r_sum_tmo;
        base_deg  = r_deg_cnt;
        base_hlt  = r_hlt_cnt;
        n_fill    = r_fill;
        if (was_full) begin
            base_resp = r_sum_resp - {{PTR_W{1'b0}}, r_win_responses[n_head]};
            base_tmo  = r_sum_tmo - {{PTR_W{1'b0}}, r_win_timeouts[n_head]};
            if (old_mark == MARK_DEGRADED) begin
                base_deg = r_deg_cnt - 1'b1;
            end else if (old_mark == MARK_HEALTHY) begin
                base_hlt = r_hlt_cnt - 1'b1;
            end
        end else begin
            n_fill = r_fill + 1'b1;
        end
    end

    assign n_sum_resp      = base_resp + {{PTR_W{1'b0}}, i_item.responses};
    assign n_sum_tmo       = base_tmo + {{PTR_W{1'b0}}, i_item.timeouts};
    assign window_activity = {1'b0, n_sum_resp} + {1'b0, n_sum_tmo};
    assign evaluate        = (n_fill == CNT_W'(WINDOW_DEPTH))
                          && (window_activity >= (SUM_W + 1)'(i_activity_floor));

    always_comb begin
        n_mark    = MARK_NONE;
        n_deg_cnt = base_deg;
        n_hlt_cnt = base_hlt;
        n_health  = r_health;
        if (evaluate) begin
            if (i_item.degraded) begin
                n_mark    = MARK_DEGRADED;
                n_deg_cnt = base_deg + 1'b1;
            end else begin
                n_mark    = MARK_HEALTHY;
                n_hlt_cnt = base_hlt + 1'b1;
            end
            if (n_sum_resp == '0) begin
                n_health = HS_OFFLINE;
            end else if (n_deg_cnt == CNT_W'(WINDOW_DEPTH)) begin
                n_health = HS_DEGRADED;
            end else if (n_hlt_cnt == CNT_W'(WINDOW_DEPTH)) begin
                n_health = HS_ONLINE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= PTR_W'(WINDOW_DEPTH - 1);
            r_fill      <= '0;
            r_sum_resp  <= '0;
            r_sum_tmo   <= '0;
            r_deg_cnt   <= '0;
            r_hlt_cnt   <= '0;
            r_health    <= HS_ONLINE;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_head      <= n_head;
                r_fill      <= n_fill;
                r_sum_resp  <= n_sum_resp;
                r_sum_tmo   <= n_sum_tmo;
                r_deg_cnt   <= n_deg_cnt;
                r_hlt_cnt   <= n_hlt_cnt;
                r_health    <= n_health;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_win_responses[n_head] <= i_item.responses;
            r_win_timeouts[n_head]  <= i_item.timeouts;
            r_win_mark[n_head]      <= n_mark;
            r_out_item.health_state <= n_health;
            r_out_item.evaluated    <= evaluate;
        end
    end

endmodule

// ===== design/windowed_timeout_health_monitor.sv =====
// ----------------------------------------------------------------------------
// windowed_timeout_health_monitor
// health state from a sliding window of per-tick response and timeout counts
// ----------------------------------------------------------------------------
// usage
//   tick requests enter on i_in_valid / o_in_ready with i_in_item; one result
//   per tick leaves on o_out_valid / i_out_ready with o_out_item
//   configuration writes use i_cfg_valid / o_cfg_ready, i_cfg_index and
//   i_cfg_data; index 0 is the activity floor, index 1 degraded_rate_q8 (low 9
//   bits); write only while no tick is in flight
//   with no stall o_out_valid rises 2 cycles after the input accept, so the
//   result can be taken at the third edge after it
//   throughput is one tick per cycle: the front stage does the rate multiply,
//   the back stage does the window read, sum update and state update in one
//   cycle each
//   a 2-entry queue and the output register let each side stall on its own;
//   a stalled receiver backs the pipeline up and o_in_ready drops once the
//   queue and the front register are full
//   synchronous reset empties the pipeline, restores the register defaults,
//   empties the window and sets the state to online; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module windowed_timeout_health_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  whm_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output whm_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [whm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [whm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import whm_pkg::*;

    logic [15:0]   r_activity_floor;
    logic [8:0]    r_degraded_rate;
    logic          cfg_write;

    logic          front_valid;
    logic          front_ready;
    t_work_item    front_item;
    logic          queue_valid;
    logic          queue_ready;
    t_work_item    queue_item;
    t_queue_status queue_status;
    t_back_status  back_status;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_activity_floor <= ACTIVITY_FLOOR_RESET;
            r_degraded_rate  <= DEGRADED_RATE_RESET;
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_ACTIVITY_FLOOR: r_activity_floor <= i_cfg_data;
                REG_DEGRADED_RATE:  r_degraded_rate  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    whm_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_ready            (o_in_ready),
        .i_item             (i_in_item),
        .i_degraded_rate_q8 (r_degraded_rate),
        .o_valid            (front_valid),
        .i_ready            (front_ready),
        .o_item             (front_item)
    );

    whm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_valid),
        .o_ready  (front_ready),
        .i_item   (front_item),
        .o_valid  (queue_valid),
        .i_ready  (queue_ready),
        .o_item   (queue_item),
        .o_status (queue_status)
    );

    whm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (queue_valid),
        .o_ready          (queue_ready),
        .i_item           (queue_item),
        .i_activity_floor (r_activity_floor),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_item           (o_out_item),
        .o_status         (back_status)
    );

    // marked entries never outnumber the filled ones
    `ASSERT_AT(a_marks_within_fill, i_clk, i_rst_n,
        ({1'b0, back_status.degraded_count} + {1'b0, back_status.healthy_count}
            <= {1'b0, back_status.fill_count}))

    // an evaluated tick only comes from a full window
    `ASSERT_AT(a_eval_needs_full, i_clk, i_rst_n,
        (o_out_valid && o_out_item.evaluated)
            |-> (back_status.fill_count == CNT_W'(WINDOW_DEPTH)))

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n,
        (queue_status.count > QCNT_W'(QUEUE_DEPTH)))

    // the health code never takes the unused value
    `ASSERT_NEVER(a_health_code, i_clk, i_rst_n,
        (o_out_valid && (o_out_item.health_state != HS_ONLINE)
            && (o_out_item.health_state != HS_DEGRADED)
            && (o_out_item.health_state != HS_OFFLINE)))

endmodule
